// ===== rtl/erld_pkg.sv =====
package erld_pkg;

	localparam int RunMinDefault      = 3;
	localparam int LongCodeBaseDefault = 224;

	localparam int CapWidth   = 25;
	localparam int CountWidth = 17;

	localparam logic [CapWidth-1:0] CapReset = 25'd65536;
	localparam logic [7:0]          LongCodeEsc = 8'hFF;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_TRUNC    = 2'd2,
		ERR_BADSTART = 2'd3
	} err_code_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       block_first;
		logic       block_last;
	} item_t;

	typedef struct packed {
		logic [7:0]            out_value;
		logic [CountWidth-1:0] repeat_count;
		logic                  block_done;
		err_code_t             error_code;
	} result_t;

endpackage

// ===== rtl/erld_if.sv =====
interface erld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       block_first;
	logic       block_last;

	modport source (output valid, code_byte, block_first, block_last, input ready);
	modport sink (input valid, code_byte, block_first, block_last, output ready);
endinterface

interface erld_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_value;
	logic [16:0] repeat_count;
	logic        block_done;
	logic [1:0]  error_code;

	modport source (output valid, out_value, repeat_count, block_done, error_code, input ready);
	modport sink (input valid, out_value, repeat_count, block_done, error_code, output ready);
endinterface

// ===== rtl/erld_decode.sv =====
module erld_decode
	import erld_pkg::*;
#(
	parameter int RUN_MIN        = RunMinDefault,
	parameter int LONG_CODE_BASE = LongCodeBaseDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CapWidth-1:0] cfg_wdata,
	input  logic                item_fire,
	input  item_t               item,
	output logic                res_valid,
	output result_t             res
);

	typedef enum logic [2:0] {
		PH_WAIT, PH_START2, PH_START3, PH_MAIN, PH_ESC, PH_MID, PH_FFHI, PH_FFLO
	} phase_t;

	localparam logic [CountWidth-1:0] ShortAdd = CountWidth'(RUN_MIN - 1);
	localparam logic [CountWidth-1:0] MidAdd   = CountWidth'(LONG_CODE_BASE + RUN_MIN - 1);
	localparam logic [CountWidth-1:0] FfAdd    =
		CountWidth'(((255 - LONG_CODE_BASE) << 8) + RUN_MIN - 1);
	localparam logic [7:0] Base8 = 8'(LONG_CODE_BASE);

	phase_t                phase_q, phase_d;
	logic [7:0]            esc_q, esc_d;
	logic [7:0]            prev_q, prev_d;
	logic [7:0]            pend_q, pend_d;
	logic [CapWidth-1:0]   pos_q, pos_d;
	logic [CapWidth-1:0]   cap_q;

	logic                  do_write;
	logic [7:0]            wr_val;
	logic [CountWidth-1:0] wr_cnt;
	logic [CapWidth:0]     pos_sum;
	logic                  ovf;
	logic                  do_fail;
	err_code_t             fail_code;
	logic [7:0]            b;

	assign b       = item.code_byte;
	assign pos_sum = {1'b0, pos_q} + {{(CapWidth+1-CountWidth){1'b0}}, wr_cnt};
	assign ovf     = pos_sum > {1'b0, cap_q};

	always_comb begin
		phase_d   = phase_q;
		esc_d     = esc_q;
		prev_d    = prev_q;
		pend_d    = pend_q;
		pos_d     = pos_q;
		do_write  = 1'b0;
		wr_val    = prev_q;
		wr_cnt    = '0;
		do_fail   = 1'b0;
		fail_code = ERR_TRUNC;
		res_valid = 1'b0;
		res       = '{out_value: 8'd0, repeat_count: '0, block_done: item.block_last,
			error_code: ERR_NONE};

		if (item.block_first) begin
			esc_d  = b;
			pos_d  = '0;
			prev_d = 8'd0;
			pend_d = 8'd0;
			if (item.block_last) begin
				phase_d   = PH_WAIT;
				res_valid = 1'b1;
			end else begin
				phase_d = PH_START2;
			end
		end else begin
			case (phase_q)
				PH_START2, PH_MAIN: begin
					if (b != esc_q) begin
						do_write = 1'b1;
						wr_val   = b;
						wr_cnt   = CountWidth'(1);
					end else if (item.block_last) begin
						do_fail = 1'b1;
					end else begin
						phase_d = (phase_q == PH_START2) ? PH_START3 : PH_ESC;
					end
				end
				PH_START3: begin
					if (b != 8'd0) begin
						do_fail   = 1'b1;
						fail_code = ERR_BADSTART;
					end else begin
						do_write = 1'b1;
						wr_val   = esc_q;
						wr_cnt   = CountWidth'(1);
					end
				end
				PH_ESC: begin
					if (b == 8'd0) begin
						do_write = 1'b1;
						wr_val   = esc_q;
						wr_cnt   = CountWidth'(1);
					end else if (b == LongCodeEsc || b >= Base8) begin
						if (item.block_last) begin
							do_fail = 1'b1;
						end else if (b == LongCodeEsc) begin
							phase_d = PH_FFHI;
						end else begin
							pend_d  = b - Base8;
							phase_d = PH_MID;
						end
					end else begin
						do_write = 1'b1;
						wr_cnt   = {{(CountWidth-8){1'b0}}, b} + ShortAdd;
					end
				end
				PH_MID: begin
					do_write = 1'b1;
					wr_cnt   = {{(CountWidth-16){1'b0}}, pend_q, b} + MidAdd;
				end
				PH_FFHI: begin
					if (item.block_last) begin
						do_fail = 1'b1;
					end else begin
						pend_d  = b;
						phase_d = PH_FFLO;
					end
				end
				PH_FFLO: begin
					do_write = 1'b1;
					wr_cnt   = {{(CountWidth-16){1'b0}}, pend_q, b} + FfAdd;
				end
				default: ;
			endcase

			if (do_write && ovf) begin
				do_fail   = 1'b1;
				fail_code = ERR_OVERFLOW;
			end

			if (do_fail) begin
				phase_d        = PH_WAIT;
				res_valid      = 1'b1;
				res.error_code = fail_code;
			end else if (do_write) begin
				pos_d            = pos_sum[CapWidth-1:0];
				prev_d           = wr_val;
				phase_d          = item.block_last ? PH_WAIT : PH_MAIN;
				res_valid        = 1'b1;
				res.out_value    = wr_val;
				res.repeat_count = wr_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			esc_q   <= 8'd0;
			prev_q  <= 8'd0;
			pend_q  <= 8'd0;
			pos_q   <= '0;
			cap_q   <= CapReset;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (item_fire) begin
				phase_q <= phase_d;
				esc_q   <= esc_d;
				prev_q  <= prev_d;
				pend_q  <= pend_d;
				pos_q   <= pos_d;
			end
		end
	end

endmodule

// ===== rtl/erld_out_reg.sv =====
module erld_out_reg
	import erld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_fire,
	input  logic       res_valid,
	input  result_t    res,
	output logic       advance,
	erld_out_if.source out_ch
);

	logic    valid_q;
	result_t res_q;

	// slot frees up in the same cycle the sink takes the held result
	assign advance = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= item_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_fire && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.out_value    = res_q.out_value;
	assign out_ch.repeat_count = res_q.repeat_count;
	assign out_ch.block_done   = res_q.block_done;
	assign out_ch.error_code   = res_q.error_code;

endmodule

// ===== rtl/escape_run_length_decoder_core.sv =====
// Escape-coded run-length decoder, one encoded byte per clock unless stalled. A byte
// enters an input register, is decoded combinationally against the block state and
// its result (if any) lands in an output register, so the block sustains one byte
// per cycle; it stalls only when the output register is full and not being taken.
// Each result is a byte value and a repeat count, or an error code; a byte that
// only advances the escape/length-code parsing gives no result. output_capacity
// may be written only while the block is idle.
module escape_run_length_decoder_core
	import erld_pkg::*;
#(
	parameter int RUN_MIN        = RunMinDefault,
	parameter int LONG_CODE_BASE = LongCodeBaseDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CapWidth-1:0] cfg_wdata,
	erld_in_if.sink             in_ch,
	erld_out_if.source          out_ch
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    item_fire;
	logic    res_valid;
	result_t res;

	assign in_ch.ready = !valid_s1 || advance;
	assign item_fire   = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= '{code_byte: in_ch.code_byte, block_first: in_ch.block_first,
				block_last: in_ch.block_last};
		end
	end

	erld_decode #(
		.RUN_MIN        (RUN_MIN),
		.LONG_CODE_BASE (LONG_CODE_BASE)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_fire (item_fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	erld_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_ch    (out_ch)
	);

endmodule

// ===== rtl/erld_checker.sv =====
module erld_checker
	import erld_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_value,
	input logic [16:0] repeat_count,
	input logic        block_done,
	input logic [1:0]  error_code
);

	// a stalled transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
		&& $stable(repeat_count) && $stable(block_done) && $stable(error_code))
		else $error("output transaction changed while stalled");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> repeat_count == 17'd0 && out_value == 8'd0)
		else $error("error result carries data");

	// a clean result with no bytes can only be the empty-block answer
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NONE && repeat_count == 17'd0
		|-> block_done && out_value == 8'd0)
		else $error("empty result outside an empty block");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind escape_run_length_decoder_core erld_checker u_erld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_value    (out_ch.out_value),
	.repeat_count (out_ch.repeat_count),
	.block_done   (out_ch.block_done),
	.error_code   (out_ch.error_code)
);
